@@ sv/wfft_pkg.sv @@
// shared types, codes and constants of the wheel force feedback torque block
package wfft_pkg;

    localparam int AXIS_MIN_DEF    = 0;
    localparam int AXIS_MAX_DEF    = 65535;
    localparam int LOOP_PERIOD_DEF = 10;

    localparam int DIVD_W   = 32;
    localparam int DIVS_W   = 16;
    localparam int DIV_ITER = DIVD_W / 2;

    localparam int POS_ONE = 16384;
    localparam int TRQ_MAX = 32767;
    localparam int TRQ_ONE = 32768;

    localparam logic [14:0] EPS_RST      = 15'd164;
    localparam logic [14:0] BRAKE_D_RST  = 15'd1638;
    localparam logic [15:0] BRAKE_R_RST  = 16'd16384;
    localparam logic [14:0] CTR_MAXT_RST = 15'd16384;
    localparam logic [14:0] CTR_MAXP_RST = 15'd16384;
    localparam logic [14:0] MIN_TRQ_RST  = 15'd3277;
    localparam logic [14:0] MAX_TRQ_RST  = 15'd32767;

    localparam logic [2:0] CFG_EPS      = 3'd0;
    localparam logic [2:0] CFG_BRAKE_D  = 3'd1;
    localparam logic [2:0] CFG_BRAKE_R  = 3'd2;
    localparam logic [2:0] CFG_CTR_MAXT = 3'd3;
    localparam logic [2:0] CFG_CTR_MAXP = 3'd4;
    localparam logic [2:0] CFG_MIN_TRQ  = 3'd5;
    localparam logic [2:0] CFG_MAX_TRQ  = 3'd6;
    localparam logic [2:0] CFG_AUTO     = 3'd7;

    typedef enum logic [2:0] {
        OP_AXIS   = 3'd0,
        OP_TARGET = 3'd1,
        OP_TICK   = 3'd2,
        OP_START  = 3'd3,
        OP_STOP   = 3'd4
    } t_op;

    typedef struct packed {
        logic axis_go;
        logic pos_wr;
        logic tgt_wr;
        logic run_on;
        logic run_off;
        logic tick_go;
        logic mul_go;
        logic cdiv_go;
        logic buf_go;
        logic torq_go;
        logic clamp_go;
        logic out_go;
    } t_cmd;

    typedef struct packed {
        logic running;
        logic center;
        logic den_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

@@ sv/wfft_div.sv @@
// radix-4 restoring unsigned divider, two quotient bits per cycle
module wfft_div import wfft_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quot
);

    localparam int CntW = $clog2(DIV_ITER);
    localparam logic [CntW-1:0] CntLast = CntW'(DIV_ITER - 1);

    logic              r_busy;
    logic              r_done;
    logic [CntW-1:0]   r_cnt;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_div;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] n_rem;
    logic [DIVD_W-1:0] n_quo;

    always_comb begin : p_step
        logic [DIVS_W:0]   v_t;
        logic [DIVS_W-1:0] v_rem;
        logic [DIVD_W-1:0] v_quo;
        v_rem = r_rem;
        v_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            v_t   = {v_rem, v_quo[DIVD_W-1]};
            v_quo = {v_quo[DIVD_W-2:0], 1'b0};
            if (v_t >= {1'b0, r_div}) begin
                v_t      = v_t - {1'b0, r_div};
                v_quo[0] = 1'b1;
            end
            v_rem = v_t[DIVS_W-1:0];
        end
        n_rem = v_rem;
        n_quo = v_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntLast) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

endmodule

@@ sv/wfft_dp.sv @@
// datapath: registers, position scaling, torque law, level scaling and output register
module wfft_dp import wfft_pkg::*; #(
    parameter int AXIS_MIN    = AXIS_MIN_DEF,
    parameter int AXIS_MAX    = AXIS_MAX_DEF,
    parameter int LOOP_PERIOD = LOOP_PERIOD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [15:0]        i_axis_value,
    input  logic signed [15:0] i_goal_position,
    input  logic signed [15:0] i_goal_torque,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [15:0] o_force_level,
    output logic [15:0]        o_envelope_length
);

    localparam int Span    = AXIS_MAX - AXIS_MIN;
    localparam int AxisSum = AXIS_MAX + AXIS_MIN;
    localparam logic AxisOk = (Span > 0);
    localparam logic [DIVS_W-1:0] AxisDivisor = AxisOk ? DIVS_W'(Span) : DIVS_W'(1);
    localparam logic [DIVD_W-1:0] AxisHalf = DIVD_W'(AxisDivisor >> 1);
    localparam logic signed [18:0] AxisOffset = 19'(AxisSum);
    localparam logic [15:0] LoopLen = 16'(LOOP_PERIOD);

    // configuration
    logic [14:0] r_eps;
    logic [14:0] r_bd;
    logic [15:0] r_btr;
    logic [14:0] r_cmt;
    logic [14:0] r_cmp;
    logic [14:0] r_mn;
    logic [14:0] r_mxt;
    logic        r_auto;

    // block state
    logic signed [15:0] r_wheel;
    logic signed [15:0] r_tpos;
    logic [14:0]        r_ttq;
    logic               r_latch;
    logic               r_run;

    // tick working registers
    logic               r_ax_neg;
    logic [16:0]        r_mag;
    logic               r_dir_neg;
    logic               r_center;
    logic               r_dead;
    logic               r_in_brake;
    logic [30:0]        r_cprod;
    logic               r_cneg;
    logic [14:0]        r_den_abs;
    logic               r_den_zero;
    logic [15:0]        r_bprod;
    logic signed [33:0] r_buf;
    logic signed [33:0] r_torq;
    logic [15:0]        r_env;
    logic [15:0]        r_tm;
    logic               r_tneg;

    // output register
    logic               r_out_valid;
    logic signed [15:0] r_force;
    logic [15:0]        r_env_o;

    logic              div_start;
    logic [DIVD_W-1:0] div_dvd;
    logic [DIVS_W-1:0] div_dvs;
    logic              div_done;
    logic [DIVD_W-1:0] div_q;

    logic signed [18:0] ax_num;
    logic [18:0]        ax_abs;
    logic [DIVD_W-1:0]  ax_dvd;
    logic [DIVD_W-1:0]  c_dvd;
    logic [15:0]        q_sat;
    logic signed [15:0] pos_new;

    logic [15:0]        gt_abs;
    logic [14:0]        gt_sat;
    logic               tgt_change;

    logic signed [16:0] err;
    logic [16:0]        err_abs;

    logic [15:0]        c_off;
    logic signed [15:0] c_span;
    logic [14:0]        c_span_abs;
    logic signed [15:0] den;
    logic [30:0]        c_prod;
    logic [30:0]        b_prod;

    logic signed [33:0] q_s;
    logic signed [33:0] buf_sum;
    logic signed [33:0] cmt_s;
    logic signed [33:0] mxt_s;
    logic signed [33:0] ttq_s;
    logic signed [33:0] bprod_s;
    logic signed [33:0] ctr_m;
    logic signed [33:0] torq_new;
    logic [15:0]        env_new;
    logic               latch_set;
    logic signed [33:0] t_clamp;
    logic [33:0]        t_abs;
    logic [30:0]        lvl_prod;
    logic [15:0]        lvl;

    // axis scaling operands
    assign ax_num = signed'({2'b00, i_axis_value, 1'b0}) - AxisOffset;
    assign ax_abs = ax_num[18] ? 19'(-ax_num) : 19'(ax_num);
    assign ax_dvd = AxisOk ? (DIVD_W'({ax_abs[16:0], 14'd0}) + AxisHalf) : '0;
    assign c_dvd  = DIVD_W'(r_cprod) + DIVD_W'(r_den_abs >> 1);

    assign div_start = i_cmd.axis_go | i_cmd.cdiv_go;
    assign div_dvd   = i_cmd.axis_go ? ax_dvd : c_dvd;
    assign div_dvs   = i_cmd.axis_go ? AxisDivisor : DIVS_W'(r_den_abs);

    wfft_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign q_sat   = (div_q > DIVD_W'(POS_ONE)) ? 16'(POS_ONE) : div_q[15:0];
    assign pos_new = r_ax_neg ? 16'(-signed'(q_sat)) : signed'(q_sat);

    // target
    assign gt_abs     = i_goal_torque[15] ? 16'(-i_goal_torque) : 16'(i_goal_torque);
    assign gt_sat     = (gt_abs > 16'(TRQ_MAX)) ? 15'(TRQ_MAX) : gt_abs[14:0];
    assign tgt_change = (i_goal_position != r_tpos) || (gt_sat != r_ttq);

    // position error
    assign err     = 17'(r_tpos) - 17'(r_wheel);
    assign err_abs = err[16] ? 17'(-err) : 17'(err);

    // ramp and brake products
    assign c_off      = r_mag[15:0] - 16'(r_eps);
    assign c_span     = signed'({1'b0, r_cmt}) - signed'({1'b0, r_mn});
    assign c_span_abs = c_span[15] ? 15'(-c_span) : c_span[14:0];
    assign den        = signed'({1'b0, r_cmp}) - signed'({1'b0, r_eps});
    assign c_prod     = 31'(c_off) * 31'(c_span_abs);
    assign b_prod     = 31'(r_ttq) * 31'(r_btr);

    // torque selection
    assign q_s     = signed'({2'b00, div_q});
    assign buf_sum = signed'({19'd0, r_mn}) + (r_cneg ? -q_s : q_s);
    assign cmt_s   = signed'({19'd0, r_cmt});
    assign mxt_s   = signed'({19'd0, r_mxt});
    assign ttq_s   = signed'({19'd0, r_ttq});
    assign bprod_s = signed'({18'd0, r_bprod});
    assign ctr_m   = (r_buf < cmt_s) ? r_buf : cmt_s;

    always_comb begin
        torq_new  = '0;
        env_new   = '0;
        latch_set = 1'b0;
        if (r_center) begin
            if (!r_dead) begin
                torq_new = r_dir_neg ? -ctr_m : ctr_m;
            end
        end else if (!r_dead) begin
            env_new = LoopLen;
            if (r_in_brake) begin
                latch_set = 1'b1;
                torq_new  = r_dir_neg ? bprod_s : -bprod_s;
            end else begin
                torq_new = r_dir_neg ? -ttq_s : ttq_s;
            end
        end
    end

    // level scaling
    assign t_clamp  = (r_torq < mxt_s) ? r_torq : mxt_s;
    assign t_abs    = t_clamp[33] ? 34'(-t_clamp) : 34'(t_clamp);
    assign lvl_prod = 31'(r_tm) * 31'(TRQ_MAX);
    assign lvl      = lvl_prod[30:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps       <= EPS_RST;
            r_bd        <= BRAKE_D_RST;
            r_btr       <= BRAKE_R_RST;
            r_cmt       <= CTR_MAXT_RST;
            r_cmp       <= CTR_MAXP_RST;
            r_mn        <= MIN_TRQ_RST;
            r_mxt       <= MAX_TRQ_RST;
            r_auto      <= 1'b0;
            r_wheel     <= '0;
            r_tpos      <= '0;
            r_ttq       <= '0;
            r_latch     <= 1'b0;
            r_run       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_EPS:      r_eps  <= i_cfg_data[14:0];
                    CFG_BRAKE_D:  r_bd   <= i_cfg_data[14:0];
                    CFG_BRAKE_R:  r_btr  <= i_cfg_data;
                    CFG_CTR_MAXT: r_cmt  <= i_cfg_data[14:0];
                    CFG_CTR_MAXP: r_cmp  <= i_cfg_data[14:0];
                    CFG_MIN_TRQ:  r_mn   <= i_cfg_data[14:0];
                    CFG_MAX_TRQ:  r_mxt  <= i_cfg_data[14:0];
                    CFG_AUTO:     r_auto <= i_cfg_data[0];
                endcase
            end
            if (i_cmd.axis_go) begin
                r_ax_neg <= ax_num[18];
            end
            if (i_cmd.pos_wr) begin
                r_wheel <= pos_new;
            end
            if (i_cmd.tgt_wr && tgt_change) begin
                r_tpos  <= i_goal_position;
                r_ttq   <= gt_sat;
                r_latch <= 1'b0;
            end
            if (i_cmd.run_on) begin
                r_run <= 1'b1;
            end
            if (i_cmd.run_off) begin
                r_run <= 1'b0;
            end
            if (i_cmd.tick_go) begin
                r_mag     <= err_abs;
                r_dir_neg <= err[16] || (err == '0);
                r_center  <= r_latch || r_auto;
            end
            if (i_cmd.mul_go) begin
                r_dead     <= r_mag < 17'(r_eps);
                r_in_brake <= r_mag < 17'(r_bd);
                r_cprod    <= c_prod;
                r_cneg     <= c_span[15] ^ den[15];
                r_den_abs  <= den[15] ? 15'(-den) : den[14:0];
                r_den_zero <= (den == '0);
                r_bprod    <= b_prod[30:15];
            end
            if (i_cmd.buf_go) begin
                r_buf <= r_den_zero ? cmt_s : buf_sum;
            end
            if (i_cmd.torq_go) begin
                r_torq <= torq_new;
                r_env  <= env_new;
                if (latch_set) begin
                    r_latch <= 1'b1;
                end
            end
            if (i_cmd.clamp_go) begin
                r_tneg <= t_clamp[33];
                r_tm   <= (t_abs > 34'(TRQ_ONE)) ? 16'(TRQ_ONE) : t_abs[15:0];
            end
            if (i_cmd.out_go) begin
                r_out_valid <= 1'b1;
                r_force     <= r_tneg ? 16'(-signed'(lvl)) : signed'(lvl);
                r_env_o     <= r_env;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.running  = r_run;
    assign o_sts.center   = r_center;
    assign o_sts.den_zero = r_den_zero;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_force_level     = r_force;
    assign o_envelope_length = r_env_o;

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_force != 16'sh8000))
        else $error("force level outside symmetric range");

    a_env_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_env_o == 16'd0) || (r_env_o == LoopLen)))
        else $error("envelope length neither zero nor loop period");

    a_latch_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_latch) |-> $past(i_cmd.torq_go))
        else $error("brake latch set outside torque step");

endmodule

@@ sv/wfft_ctrl.sv @@
// controller: sequences the datapath for each accepted item
module wfft_ctrl import wfft_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_op,
    output logic       o_in_ready,
    output t_cmd       o_cmd,
    input  t_sts       i_sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_AXIS_W,
        S_T_MUL,
        S_T_DIV,
        S_T_DIVW,
        S_T_BUF,
        S_T_TORQ,
        S_T_CLAMP,
        S_T_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_op))
                        OP_AXIS: begin
                            o_cmd.axis_go = 1'b1;
                            n_state       = S_AXIS_W;
                        end
                        OP_TARGET: o_cmd.tgt_wr  = 1'b1;
                        OP_START:  o_cmd.run_on  = 1'b1;
                        OP_STOP:   o_cmd.run_off = 1'b1;
                        OP_TICK: begin
                            if (i_sts.running) begin
                                o_cmd.tick_go = 1'b1;
                                n_state       = S_T_MUL;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_AXIS_W: begin
                if (i_sts.div_done) begin
                    o_cmd.pos_wr = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_T_MUL: begin
                o_cmd.mul_go = 1'b1;
                n_state      = S_T_DIV;
            end
            S_T_DIV: begin
                if (i_sts.center && !i_sts.den_zero) begin
                    o_cmd.cdiv_go = 1'b1;
                    n_state       = S_T_DIVW;
                end else begin
                    n_state = S_T_BUF;
                end
            end
            S_T_DIVW: begin
                if (i_sts.div_done) begin
                    n_state = S_T_BUF;
                end
            end
            S_T_BUF: begin
                o_cmd.buf_go = 1'b1;
                n_state      = S_T_TORQ;
            end
            S_T_TORQ: begin
                o_cmd.torq_go = 1'b1;
                n_state       = S_T_CLAMP;
            end
            S_T_CLAMP: begin
                o_cmd.clamp_go = 1'b1;
                n_state        = S_T_OUT;
            end
            S_T_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_go = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/wheel_force_feedback_torque.sv @@
// top level of the wheel force feedback torque block
// axis item: scaled by the radix-4 divider, written as wheel position; target, start, stop:
// done on acceptance; tick item while running: multiply, ramp divide when centering with
// nonzero denominator, buffer, torque, clamp, output; no new item until the tick is done
// a finished result waits in the output register while other items are taken
// synchronous active-low reset loads register defaults, clears state and sets running
module wheel_force_feedback_torque import wfft_pkg::*; #(
    parameter int AXIS_MIN    = AXIS_MIN_DEF,
    parameter int AXIS_MAX    = AXIS_MAX_DEF,
    parameter int LOOP_PERIOD = LOOP_PERIOD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_op,
    input  logic [15:0]        i_axis_value,
    input  logic signed [15:0] i_goal_position,
    input  logic signed [15:0] i_goal_torque,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_force_level,
    output logic [15:0]        o_envelope_length,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    wfft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    wfft_dp #(
        .AXIS_MIN    (AXIS_MIN),
        .AXIS_MAX    (AXIS_MAX),
        .LOOP_PERIOD (LOOP_PERIOD)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_axis_value      (i_axis_value),
        .i_goal_position   (i_goal_position),
        .i_goal_torque     (i_goal_torque),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_force_level     (o_force_level),
        .o_envelope_length (o_envelope_length)
    );

endmodule
